// ----- sv/sgn_pkg.sv -----
`timescale 1ns / 1ps

package sgn_pkg;

   localparam int PosBits = 32;
   localparam int SeqCountBits = 16;
   localparam int GapBits = 16;
   localparam int CsrDataBits = 16;
   localparam int CsrIndexBits = 2;
   localparam int WideBits = ((PosBits > GapBits) ? PosBits : GapBits) + 1;

   localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
   localparam logic [7:0] UnknownBase = 8'd78;

   localparam logic [GapBits-1:0] MaxGapReset = 16'd200;
   localparam logic [GapBits-1:0] MinGapReset = 16'd10;
   localparam logic [GapBits-1:0] MinTailReset = 16'd10;

   localparam logic [CsrIndexBits-1:0] CsrMaxGap = 2'd0;
   localparam logic [CsrIndexBits-1:0] CsrMinGap = 2'd1;
   localparam logic [CsrIndexBits-1:0] CsrMinTail = 2'd2;

   typedef struct packed {
      logic [7:0] base;
      logic       end_of_sequence;
   } req_type;

   typedef struct packed {
      logic [15:0] sequence_number;
      logic [31:0] input_start;
      logic [31:0] segment_length;
      logic [31:0] output_offset;
      logic [15:0] following_gap;
   } rsp_type;

   typedef struct packed {
      logic [GapBits-1:0] max_gap;
      logic [GapBits-1:0] min_gap;
      logic [GapBits-1:0] min_tail;
   } cfg_type;

   function automatic logic [PosBits-1:0] span(input logic [PosBits-1:0] stop,
                                                input logic [PosBits-1:0] start);
      return (stop > start) ? stop - start : '0;
   endfunction

   function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] value);
      return (value == PosMax) ? value : value + PosBits'(1);
   endfunction

   function automatic logic [GapBits-1:0] resize_run(input logic [PosBits-1:0] len,
                                                      input logic [GapBits-1:0] max_gap,
                                                      input logic [GapBits-1:0] min_gap);
      logic [GapBits-1:0] result;
      if (WideBits'(len) >= WideBits'(max_gap)) begin
         result = max_gap;
      end else if (len == PosBits'(2)) begin
         result = min_gap;
      end else begin
         result = GapBits'(len);
      end
      return result;
   endfunction

endpackage

// ----- sv/sgn_csr.sv -----
`timescale 1ns / 1ps

module sgn_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [sgn_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [sgn_pkg::CsrDataBits-1:0]  csr_write_data,
   output sgn_pkg::cfg_type               cfg
);
   import sgn_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CsrMaxGap:  cfg_in.max_gap = csr_write_data;
            CsrMinGap:  cfg_in.min_gap = csr_write_data;
            CsrMinTail: cfg_in.min_tail = csr_write_data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_gap <= MaxGapReset;
         cfg_ff.min_gap <= MinGapReset;
         cfg_ff.min_tail <= MinTailReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/sgn_core.sv -----
`timescale 1ns / 1ps

module sgn_core (
   input  logic             clock,
   input  logic             reset,
   input  sgn_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  sgn_pkg::req_type req_payload,
   output logic             result_valid,
   output sgn_pkg::rsp_type result,
   input  logic             out_free
);
   import sgn_pkg::*;

   logic                     s1_valid_ff;
   req_type                  s1_payload_ff;
   logic [PosBits-1:0]       position_ff, position_in;
   logic [PosBits-1:0]       segment_start_ff, segment_start_in;
   logic [PosBits-1:0]       run_length_ff, run_length_in;
   logic [PosBits-1:0]       run_begin_ff, run_begin_in;
   logic [PosBits-1:0]       resized_offset_ff, resized_offset_in;
   logic [SeqCountBits-1:0]  sequence_count_ff, sequence_count_in;

   logic                     req_accept, advance;
   logic                     is_n, eos;
   logic                     close_long, close_single, emit_close;
   logic                     run_n_long, emit_eos_long, emit_tail, emit;
   logic [PosBits-1:0]       pos_inc, run_length_n, run_begin_n, seg_start_n;
   logic [PosBits-1:0]       len_close, len_eos_long, len_tail;
   logic [PosBits-1:0]       len_emit, start_emit, run_sel, seg_plus_gap, new_offset;
   logic [GapBits-1:0]       gap_emit;
   logic [WideBits-1:0]      sum_seg, sum_off;

   assign is_n = (s1_payload_ff.base == UnknownBase);
   assign eos = s1_payload_ff.end_of_sequence;
   assign pos_inc = sat_inc(position_ff);

   // run tracking
   assign run_length_n = is_n ? sat_inc(run_length_ff) : '0;
   assign run_begin_n = (is_n && (run_length_ff == '0)) ? position_ff : run_begin_ff;

   // segment closed by the run that just ended
   assign close_long = !is_n && (run_length_ff >= PosBits'(2));
   assign close_single = !is_n && (run_length_ff == PosBits'(1)) && (run_begin_ff != '0);
   assign len_close = span(run_begin_ff, segment_start_ff);
   assign emit_close = (close_long || close_single) && (len_close != '0);
   assign seg_start_n = (close_long || close_single) ? position_ff : segment_start_ff;

   // end of sequence
   assign run_n_long = is_n && (run_length_n >= PosBits'(2));
   assign len_eos_long = span(run_begin_n, segment_start_ff);
   assign len_tail = span(pos_inc, seg_start_n);
   assign emit_eos_long = eos && run_n_long && (len_eos_long != '0);
   assign emit_tail = eos && !run_n_long && !emit_close && (len_tail != '0)
                      && (WideBits'(len_tail) >= WideBits'(cfg.min_tail));
   assign emit = emit_close || emit_eos_long || emit_tail;

   assign len_emit = emit_close ? len_close : (run_n_long ? len_eos_long : len_tail);
   assign start_emit = emit_close ? segment_start_ff : seg_start_n;
   assign run_sel = close_long ? run_length_ff : run_length_n;

   always_comb begin
      if (emit_tail) begin
         gap_emit = '0;
      end else if (close_single) begin
         gap_emit = cfg.min_gap;
      end else begin
         gap_emit = resize_run(run_sel, cfg.max_gap, cfg.min_gap);
      end
   end

   assign sum_seg = WideBits'(len_emit) + WideBits'(gap_emit);
   assign seg_plus_gap = (sum_seg > WideBits'(PosMax)) ? PosMax : PosBits'(sum_seg);
   assign sum_off = WideBits'(resized_offset_ff) + WideBits'(seg_plus_gap);
   assign new_offset = (sum_off > WideBits'(PosMax)) ? PosMax : PosBits'(sum_off);

   assign result.sequence_number = 16'(sequence_count_ff);
   assign result.input_start = 32'(start_emit);
   assign result.segment_length = 32'(len_emit);
   assign result.output_offset = 32'(resized_offset_ff);
   assign result.following_gap = gap_emit;

   assign result_valid = s1_valid_ff && emit;
   assign advance = s1_valid_ff && (!emit || out_free);
   assign req_stall = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      position_in = position_ff;
      segment_start_in = segment_start_ff;
      run_length_in = run_length_ff;
      run_begin_in = run_begin_ff;
      resized_offset_in = resized_offset_ff;
      sequence_count_in = sequence_count_ff;
      if (advance) begin
         if (eos) begin
            position_in = '0;
            segment_start_in = '0;
            run_length_in = '0;
            run_begin_in = '0;
            resized_offset_in = '0;
            sequence_count_in = sequence_count_ff + SeqCountBits'(1);
         end else begin
            position_in = pos_inc;
            segment_start_in = seg_start_n;
            run_length_in = run_length_n;
            run_begin_in = run_begin_n;
            if (emit) begin
               resized_offset_in = new_offset;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         position_ff <= '0;
         segment_start_ff <= '0;
         run_length_ff <= '0;
         run_begin_ff <= '0;
         resized_offset_ff <= '0;
         sequence_count_ff <= '0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         position_ff <= position_in;
         segment_start_ff <= segment_start_in;
         run_length_ff <= run_length_in;
         run_begin_ff <= run_begin_in;
         resized_offset_ff <= resized_offset_in;
         sequence_count_ff <= sequence_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_payload_ff <= req_payload;
      end
   end

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && eos) |=> (position_ff == '0 && resized_offset_ff == '0))
      else $error("state not cleared after end of sequence");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (len_emit != '0))
      else $error("empty segment reported");

   a_start_order: assert property (@(posedge clock) disable iff (reset)
      segment_start_ff <= position_ff)
      else $error("segment start beyond position");

endmodule

// ----- sv/sgn_out.sv -----
`timescale 1ns / 1ps

module sgn_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             result_valid,
   input  sgn_pkg::rsp_type result,
   output logic             out_free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sgn_pkg::rsp_type rsp_payload
);
   import sgn_pkg::*;

   logic    rsp_valid_ff;
   rsp_type rsp_payload_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= result_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && result_valid) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- sv/sequence_gap_normalizer.sv -----
`timescale 1ns / 1ps
// a beat waits in the input register; its segment enters the result register when that is free
// throughput: one base per cycle, set by the input register and per-base state update, while
// the result side is free; a base that closes no segment leaves without waiting for it
// reset: synchronous, active high; clears counters, valid flags and sets config to 200/10/10
// no clearing pass; the block accepts beats as soon as reset is released

module sequence_gap_normalizer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sgn_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sgn_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_write_enable,
   input  logic [sgn_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [sgn_pkg::CsrDataBits-1:0]  csr_write_data
);
   import sgn_pkg::*;

   cfg_type cfg;
   rsp_type result;
   logic    result_valid;
   logic    out_free;

   sgn_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   sgn_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .result_valid (result_valid),
      .result       (result),
      .out_free     (out_free)
   );

   sgn_out u_out (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .out_free     (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule
